>>> src/vwa_pkg.sv
// ----------------------------------------------------------------------------
// vwa_pkg
// Shared types and constants for the vector window averager.
// ----------------------------------------------------------------------------
package vwa_pkg;

    localparam int MAX_ELEMENTS_DEF = 64;
    localparam int MAX_WINDOW_DEF   = 256;

    localparam int SAMPLE_W  = 24;
    localparam int SUM_W     = 40;
    localparam int CNT_W     = 16;
    localparam int INDEX_W   = 6;
    localparam int EC_W      = 7;
    localparam int WL_W      = 9;
    localparam int CFG_W     = 9;
    localparam int CFG_IDX_W = 2;
    localparam int FUNC_W    = 2;

    // divider: quotient bits retired per cycle
    localparam int DIV_BITS   = 2;
    localparam int DIV_CYCLES = SUM_W / DIV_BITS;
    localparam int DIV_CNT_W  = $clog2(DIV_CYCLES + 1);

    localparam logic [FUNC_W-1:0] FUNC_FEED    = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_RESTART = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_FORCE   = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_ELEMENT_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LEN    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MOVING_MODE   = 2'd2;

    localparam logic signed [SUM_W-1:0] SUM_HI = {1'b0, {(SUM_W-1){1'b1}}};
    localparam logic signed [SUM_W-1:0] SUM_LO = {1'b1, {(SUM_W-1){1'b0}}};

    localparam logic signed [SAMPLE_W-1:0] AVG_HI = {1'b0, {(SAMPLE_W-1){1'b1}}};
    localparam logic signed [SAMPLE_W-1:0] AVG_LO = {1'b1, {(SAMPLE_W-1){1'b0}}};

    typedef struct packed {
        logic [FUNC_W-1:0]          func;
        logic signed [SAMPLE_W-1:0] sample;
    } in_word_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] average;
        logic [INDEX_W-1:0]         element_index;
        logic                       last_element;
    } out_word_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_ACCESS,
        ST_DIVIDE
    } state_t;

endpackage

>>> src/vwa_ram.sv
// ----------------------------------------------------------------------------
// vwa_ram
// Simple dual-port synchronous RAM, one write and one registered read.
// ----------------------------------------------------------------------------
module vwa_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 64,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> src/vwa_div.sv
// ----------------------------------------------------------------------------
// vwa_div
// Iterative signed-by-unsigned divider, truncating, result clamped to 24 bits.
// ----------------------------------------------------------------------------
module vwa_div (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic signed [vwa_pkg::SUM_W-1:0]  dividend,
    input  logic [vwa_pkg::CNT_W-1:0]         divisor,
    output vwa_pkg::div_status_t              status,
    output logic signed [vwa_pkg::SAMPLE_W-1:0] quotient
);

    localparam int SW = vwa_pkg::SUM_W;
    localparam int CW = vwa_pkg::CNT_W;
    localparam int AW = vwa_pkg::SAMPLE_W;

    logic                           busy_reg, busy_next;
    logic                           done_reg, done_next;
    logic                           prep_reg, prep_next;
    logic [vwa_pkg::DIV_CNT_W-1:0]  cnt_reg, cnt_next;
    logic                           neg_reg, neg_next;
    logic                           zero_reg, zero_next;
    logic [SW-1:0]                  quo_reg, quo_next;
    logic [CW-1:0]                  rem_reg, rem_next;
    logic [CW-1:0]                  den_reg, den_next;

    logic [SW-1:0] q_step;
    logic [CW-1:0] r_step;
    logic [CW:0]   trial;

    always_comb
    begin
        q_step = quo_reg;
        r_step = rem_reg;
        trial  = '0;
        for (int i = 0; i < vwa_pkg::DIV_BITS; i++)
        begin
            trial  = {r_step, q_step[SW-1]};
            q_step = {q_step[SW-2:0], 1'b0};
            if (trial >= {1'b0, den_reg})
            begin
                trial     = trial - {1'b0, den_reg};
                q_step[0] = 1'b1;
            end
            r_step = trial[CW-1:0];
        end
    end

    always_comb
    begin
        busy_next = busy_reg;
        done_next = done_reg;
        prep_next = 1'b0;
        cnt_next  = cnt_reg;
        neg_next  = neg_reg;
        zero_next = zero_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        if (start)
        begin
            busy_next = 1'b1;
            done_next = 1'b0;
            prep_next = 1'b1;
            cnt_next  = '0;
            neg_next  = dividend[SW-1];
            zero_next = (divisor == '0);
            quo_next  = dividend;
            rem_next  = '0;
            den_next  = divisor;
        end
        else if (prep_reg)
        begin
            if (neg_reg)
            begin
                quo_next = -quo_reg;
            end
        end
        else if (busy_reg)
        begin
            quo_next = q_step;
            rem_next = r_step;
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == vwa_pkg::DIV_CNT_W'(vwa_pkg::DIV_CYCLES - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            prep_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            prep_reg <= prep_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        neg_reg  <= neg_next;
        zero_reg <= zero_next;
        quo_reg  <= quo_next;
        rem_reg  <= rem_next;
        den_reg  <= den_next;
    end

    always_comb
    begin
        if (zero_reg)
        begin
            quotient = '0;
        end
        else if (!neg_reg)
        begin
            quotient = (quo_reg > SW'(vwa_pkg::AVG_HI)) ? vwa_pkg::AVG_HI : AW'(quo_reg);
        end
        else
        begin
            quotient = (quo_reg > {{(SW-AW){1'b0}}, vwa_pkg::AVG_LO}) ? vwa_pkg::AVG_LO
                                                                      : -AW'(quo_reg);
        end
    end

    assign status.busy = busy_reg;
    assign status.done = done_reg;

endmodule

>>> src/vector_window_average_top.sv
// ----------------------------------------------------------------------------
// vector_window_average_top
// Windowed or cumulative per-element average of a stream of vectors.
// ----------------------------------------------------------------------------
// After reset and after every restart word the block sweeps the ring and sum
// RAMs to zero, one ring entry per cycle over all MAX_WINDOW * MAX_ELEMENTS
// entries, during which item_stall is high. A feed word that gives no result
// is accepted, then its RAM read-modify-write is done. A word that gives a
// result also goes through the divider, which retires two quotient bits a
// cycle over the 40-bit sum. Results sit in an output register so the next
// word is taken while one waits on result_stall.
// ----------------------------------------------------------------------------
module vector_window_average_top #(
    parameter int MAX_ELEMENTS = vwa_pkg::MAX_ELEMENTS_DEF,
    parameter int MAX_WINDOW   = vwa_pkg::MAX_WINDOW_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            item_valid,
    output logic                            item_stall,
    input  vwa_pkg::in_word_t               item,
    output logic                            result_valid,
    input  logic                            result_stall,
    output vwa_pkg::out_word_t              result,
    input  logic                            write_enable,
    input  logic [vwa_pkg::CFG_IDX_W-1:0]   reg_index,
    input  logic [vwa_pkg::CFG_W-1:0]       write_data
);

    localparam int SW         = vwa_pkg::SUM_W;
    localparam int XW         = vwa_pkg::SAMPLE_W;
    localparam int CW         = vwa_pkg::CNT_W;
    localparam int RING_DEPTH = MAX_WINDOW * MAX_ELEMENTS;
    localparam int RING_AW    = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam int POS_W      = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
    localparam int SLOT_W     = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int LEN_W      = $clog2(MAX_WINDOW + 1) + 1;
    localparam int EL_W0      = $clog2(MAX_ELEMENTS + 1) + 1;
    localparam int EW         = (EL_W0 > vwa_pkg::EC_W) ? EL_W0 : vwa_pkg::EC_W;
    localparam int WL0        = (LEN_W > vwa_pkg::WL_W) ? LEN_W : vwa_pkg::WL_W;
    localparam int WLW        = (WL0 > CW) ? WL0 : CW;

    vwa_pkg::state_t state_reg, state_next;

    logic [vwa_pkg::EC_W-1:0] element_count_reg, element_count_next;
    logic [vwa_pkg::WL_W-1:0] window_len_reg, window_len_next;
    logic                     moving_mode_reg, moving_mode_next;

    logic [RING_AW-1:0] clr_cnt_reg, clr_cnt_next;
    logic [POS_W-1:0]   sum_clr_reg, sum_clr_next;
    logic [SLOT_W-1:0]  ring_slot_reg, ring_slot_next;
    logic [CW-1:0]      filled_reg, filled_next;
    logic [POS_W-1:0]   pos_reg, pos_next;
    logic               cumulative_reg, cumulative_next;
    logic               lmoving_reg, lmoving_next;
    logic               emit_reg, emit_next;
    logic [LEN_W-1:0]   llen_reg, llen_next;

    logic signed [XW-1:0] x_reg, x_next;
    logic                 force_reg, force_next;
    logic [POS_W-1:0]     acc_pos_reg, acc_pos_next;
    logic [RING_AW-1:0]   acc_idx_reg, acc_idx_next;
    logic                 acc_last_reg, acc_last_next;

    logic                 result_valid_reg, result_valid_next;
    vwa_pkg::out_word_t   result_reg, result_next;

    logic               accept;
    logic [EW-1:0]      vlen;
    logic [EW-1:0]      ec_ext;
    logic [EW-1:0]      pos_ext;
    logic [POS_W-1:0]   pos_cur;
    logic [EW-1:0]      pos_inc;
    logic [LEN_W-1:0]   slot_cur;
    logic [LEN_W-1:0]   slot_new;
    logic [LEN_W-1:0]   slot_inc;
    logic [RING_AW-1:0] ring_idx;
    logic [WLW-1:0]     wl_ext;
    logic [WLW-1:0]     filled_ext;
    logic [WLW-1:0]     llen_ext;

    logic               ring_we;
    logic [RING_AW-1:0] ring_waddr;
    logic [XW-1:0]      ring_wdata;
    logic [XW-1:0]      ring_rdata;
    logic               sum_we;
    logic [POS_W-1:0]   sum_waddr;
    logic [SW-1:0]      sum_wdata;
    logic [SW-1:0]      sum_rdata;

    logic signed [SW+1:0] sum_wide;
    logic signed [SW-1:0] sum_new;
    logic signed [XW-1:0] ring_old;

    logic                   div_start;
    logic signed [SW-1:0]   div_dividend;
    vwa_pkg::div_status_t   div_status;
    logic signed [XW-1:0]   div_quotient;
    logic                   out_free;

    // configuration
    always_comb
    begin
        element_count_next = element_count_reg;
        window_len_next    = window_len_reg;
        moving_mode_next   = moving_mode_reg;
        if (write_enable)
        begin
            unique case (reg_index)
                vwa_pkg::CFG_ELEMENT_COUNT: element_count_next = write_data[vwa_pkg::EC_W-1:0];
                vwa_pkg::CFG_WINDOW_LEN:    window_len_next    = write_data[vwa_pkg::WL_W-1:0];
                vwa_pkg::CFG_MOVING_MODE:   moving_mode_next   = write_data[0];
                default: ;
            endcase
        end
    end

    assign accept   = item_valid && !item_stall;
    assign out_free = !result_valid_reg || !result_stall;

    // vector length and element position
    always_comb
    begin
        ec_ext   = EW'(element_count_reg);
        if (ec_ext == '0)
        begin
            vlen = EW'(1);
        end
        else if (ec_ext > EW'(MAX_ELEMENTS))
        begin
            vlen = EW'(MAX_ELEMENTS);
        end
        else
        begin
            vlen = ec_ext;
        end
        pos_ext  = EW'(pos_reg);
        pos_cur  = (pos_ext >= vlen) ? '0 : pos_reg;
        pos_inc  = EW'(pos_cur) + 1'b1;
        slot_cur = (LEN_W'(ring_slot_reg) >= llen_reg) ? '0 : LEN_W'(ring_slot_reg);
        slot_inc = slot_cur + 1'b1;
        slot_new = (pos_cur == '0) ? ((slot_inc == llen_reg) ? '0 : slot_inc) : slot_cur;
        ring_idx = RING_AW'(slot_new) * RING_AW'(MAX_ELEMENTS) + RING_AW'(pos_cur);
        wl_ext     = WLW'(window_len_reg);
        filled_ext = WLW'(filled_reg);
        llen_ext   = WLW'(llen_reg);
    end

    // sum update
    always_comb
    begin
        ring_old = cumulative_reg ? '0 : $signed(ring_rdata);
        sum_wide = (SW+2)'($signed(sum_rdata)) - (SW+2)'(ring_old) + (SW+2)'(x_reg);
        if (sum_wide > (SW+2)'(vwa_pkg::SUM_HI))
        begin
            sum_new = vwa_pkg::SUM_HI;
        end
        else if (sum_wide < (SW+2)'(vwa_pkg::SUM_LO))
        begin
            sum_new = vwa_pkg::SUM_LO;
        end
        else
        begin
            sum_new = sum_wide[SW-1:0];
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            vwa_pkg::ST_CLEAR:
            begin
                if (clr_cnt_reg == RING_AW'(RING_DEPTH - 1))
                begin
                    state_next = vwa_pkg::ST_IDLE;
                end
            end
            vwa_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    if (item.func == vwa_pkg::FUNC_RESTART)
                    begin
                        state_next = vwa_pkg::ST_CLEAR;
                    end
                    else if (item.func == vwa_pkg::FUNC_FEED
                             || (item.func == vwa_pkg::FUNC_FORCE && cumulative_reg))
                    begin
                        state_next = vwa_pkg::ST_ACCESS;
                    end
                end
            end
            vwa_pkg::ST_ACCESS:
            begin
                state_next = div_start ? vwa_pkg::ST_DIVIDE : vwa_pkg::ST_IDLE;
            end
            vwa_pkg::ST_DIVIDE:
            begin
                if (div_status.done && out_free)
                begin
                    state_next = vwa_pkg::ST_IDLE;
                end
            end
            default: state_next = vwa_pkg::ST_IDLE;
        endcase
    end

    // outputs and datapath
    always_comb
    begin
        item_stall = (state_reg != vwa_pkg::ST_IDLE);

        clr_cnt_next    = clr_cnt_reg;
        sum_clr_next    = sum_clr_reg;
        ring_slot_next  = ring_slot_reg;
        filled_next     = filled_reg;
        pos_next        = pos_reg;
        cumulative_next = cumulative_reg;
        lmoving_next    = lmoving_reg;
        emit_next       = emit_reg;
        llen_next       = llen_reg;
        x_next          = x_reg;
        force_next      = force_reg;
        acc_pos_next    = acc_pos_reg;
        acc_idx_next    = acc_idx_reg;
        acc_last_next   = acc_last_reg;

        ring_we      = 1'b0;
        ring_waddr   = acc_idx_reg;
        ring_wdata   = x_reg;
        sum_we       = 1'b0;
        sum_waddr    = acc_pos_reg;
        sum_wdata    = sum_new;
        div_start    = 1'b0;
        div_dividend = sum_new;

        result_valid_next = result_valid_reg && result_stall;
        result_next       = result_reg;

        unique case (state_reg)
            vwa_pkg::ST_CLEAR:
            begin
                ring_we      = 1'b1;
                ring_waddr   = clr_cnt_reg;
                ring_wdata   = '0;
                sum_we       = 1'b1;
                sum_waddr    = sum_clr_reg;
                sum_wdata    = '0;
                clr_cnt_next = clr_cnt_reg + 1'b1;
                sum_clr_next = (sum_clr_reg == POS_W'(MAX_ELEMENTS - 1)) ? '0
                                                                         : sum_clr_reg + 1'b1;
            end
            vwa_pkg::ST_IDLE:
            begin
                clr_cnt_next = '0;
                sum_clr_next = '0;
                if (accept)
                begin
                    x_next        = item.sample;
                    acc_pos_next  = pos_cur;
                    acc_idx_next  = ring_idx;
                    acc_last_next = (pos_inc == vlen);
                    force_next    = (item.func == vwa_pkg::FUNC_FORCE);
                    if (item.func == vwa_pkg::FUNC_RESTART)
                    begin
                        if (wl_ext == '0)
                        begin
                            cumulative_next = 1'b1;
                            lmoving_next    = 1'b0;
                            llen_next       = LEN_W'(1);
                        end
                        else
                        begin
                            cumulative_next = 1'b0;
                            lmoving_next    = moving_mode_reg;
                            llen_next       = (wl_ext > WLW'(MAX_WINDOW)) ? LEN_W'(MAX_WINDOW)
                                                                          : LEN_W'(wl_ext);
                        end
                        ring_slot_next = '0;
                        filled_next    = '0;
                        pos_next       = '0;
                        emit_next      = 1'b0;
                    end
                    else if (item.func == vwa_pkg::FUNC_FEED)
                    begin
                        pos_next = (pos_inc >= vlen) ? '0 : POS_W'(pos_inc);
                        if (cumulative_reg)
                        begin
                            if (pos_cur == '0 && filled_reg != '1)
                            begin
                                filled_next = filled_reg + 1'b1;
                            end
                        end
                        else
                        begin
                            ring_slot_next = SLOT_W'(slot_new);
                            if (pos_cur == '0)
                            begin
                                filled_next = (filled_ext < llen_ext) ? filled_reg + 1'b1
                                                                      : CW'(llen_reg);
                                emit_next   = lmoving_reg || (slot_new == '0);
                            end
                        end
                    end
                    else if (item.func == vwa_pkg::FUNC_FORCE && cumulative_reg)
                    begin
                        pos_next = (pos_inc >= vlen) ? '0 : POS_W'(pos_inc);
                    end
                end
            end
            vwa_pkg::ST_ACCESS:
            begin
                if (force_reg)
                begin
                    div_start    = 1'b1;
                    div_dividend = $signed(sum_rdata);
                end
                else
                begin
                    sum_we    = 1'b1;
                    ring_we   = !cumulative_reg;
                    div_start = !cumulative_reg && emit_reg;
                end
            end
            vwa_pkg::ST_DIVIDE:
            begin
                if (div_status.done && out_free)
                begin
                    result_valid_next          = 1'b1;
                    result_next.average        = div_quotient;
                    result_next.element_index  = vwa_pkg::INDEX_W'(acc_pos_reg);
                    result_next.last_element   = acc_last_reg;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= vwa_pkg::ST_CLEAR;
            element_count_reg <= vwa_pkg::EC_W'(1);
            window_len_reg    <= '0;
            moving_mode_reg   <= 1'b0;
            clr_cnt_reg       <= '0;
            sum_clr_reg       <= '0;
            ring_slot_reg     <= '0;
            filled_reg        <= '0;
            pos_reg           <= '0;
            cumulative_reg    <= 1'b0;
            lmoving_reg       <= 1'b0;
            emit_reg          <= 1'b0;
            llen_reg          <= LEN_W'(1);
            result_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg         <= state_next;
            element_count_reg <= element_count_next;
            window_len_reg    <= window_len_next;
            moving_mode_reg   <= moving_mode_next;
            clr_cnt_reg       <= clr_cnt_next;
            sum_clr_reg       <= sum_clr_next;
            ring_slot_reg     <= ring_slot_next;
            filled_reg        <= filled_next;
            pos_reg           <= pos_next;
            cumulative_reg    <= cumulative_next;
            lmoving_reg       <= lmoving_next;
            emit_reg          <= emit_next;
            llen_reg          <= llen_next;
            result_valid_reg  <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg        <= x_next;
        force_reg    <= force_next;
        acc_pos_reg  <= acc_pos_next;
        acc_idx_reg  <= acc_idx_next;
        acc_last_reg <= acc_last_next;
        result_reg   <= result_next;
    end

    vwa_ram #(
        .WIDTH (XW),
        .DEPTH (RING_DEPTH)
    ) u_ring (
        .clk   (clk),
        .we    (ring_we),
        .waddr (ring_waddr),
        .wdata (ring_wdata),
        .raddr (ring_idx),
        .rdata (ring_rdata)
    );

    vwa_ram #(
        .WIDTH (SW),
        .DEPTH (MAX_ELEMENTS)
    ) u_sum (
        .clk   (clk),
        .we    (sum_we),
        .waddr (sum_waddr),
        .wdata (sum_wdata),
        .raddr (pos_cur),
        .rdata (sum_rdata)
    );

    vwa_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (filled_reg),
        .status   (div_status),
        .quotient (div_quotient)
    );

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule
